FILE: sv/ppsd_pkg.sv
// Shared widths, codes, reset values and word types of the pitch step detector.
package ppsd_pkg;

	localparam int PITCH_W     = 17;
	localparam int TIME_W      = 40;
	localparam int COUNT_W     = 32;
	localparam int TREND_W     = 2;
	localparam int INTERVAL_W  = 16;
	localparam int DEADBAND_W  = 15;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_INDEX_W = 1;

	localparam int PITCH_LIMIT = 46080;

	localparam int WINDOW_DEFAULT    = 10;
	localparam int MID_DEPTH_DEFAULT = 4;
	localparam int OUT_DEPTH_DEFAULT = 4;

	localparam logic [CFG_INDEX_W-1:0] REG_MIN_INTERVAL = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_DEADBAND     = 1'b1;

	localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd300;
	localparam logic [DEADBAND_W-1:0] DEADBAND_RESET = 15'd26;

	localparam logic [TREND_W-1:0] TREND_UNKNOWN = 2'd0;
	localparam logic [TREND_W-1:0] TREND_RISING  = 2'd1;
	localparam logic [TREND_W-1:0] TREND_FALLING = 2'd2;

	typedef struct packed {
		logic [INTERVAL_W-1:0] min_interval;
		logic [DEADBAND_W-1:0] deadband;
	} cfg_t;

	typedef struct packed {
		logic               step_detected;
		logic [COUNT_W-1:0] total_steps;
		logic [TREND_W-1:0] trend;
	} result_t;

endpackage

FILE: sv/pitch_peak_step_detector_unit.sv
// Top level of the pitch step detector: config registers, front, mid queue, back, result queue.
//
//  channel   dir  handshake            fields
//  -------   ---  -------------------  -------------------------------------------
//  sample    in   push / full          pitch_sample (s17, Q8.8), time_ms (u40)
//  result    out  empty / pop          step_detected, total_steps (u32), trend (u2)
//  config    in   cfg_we (no wait)     cfg_index, cfg_data
//
// One word per clock in both directions while the reader keeps popping. An accepted
// sample word passes these steps in order: front writes the mid queue, the back pops
// it through the multiply into s1, and trend and step logic push the result.
// Reset clears the window, sum, trend, step count and both queues at once.
// full rises only when the mid queue fills; the back issues a word only while the
// result queue has room for it, so a stalled reader backs up through both queues.
module pitch_peak_step_detector_unit #(
	parameter int WINDOW    = ppsd_pkg::WINDOW_DEFAULT,
	parameter int MID_DEPTH = ppsd_pkg::MID_DEPTH_DEFAULT,
	parameter int OUT_DEPTH = ppsd_pkg::OUT_DEPTH_DEFAULT
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// sample side
	input  logic                                   push,
	output logic                                   full,
	input  logic signed [ppsd_pkg::PITCH_W-1:0]    pitch_sample,
	input  logic [ppsd_pkg::TIME_W-1:0]            time_ms,
	// result side
	output logic                                   empty,
	input  logic                                   pop,
	output logic                                   step_detected,
	output logic [ppsd_pkg::COUNT_W-1:0]           total_steps,
	output logic [ppsd_pkg::TREND_W-1:0]           trend,
	// configuration
	input  logic                                   cfg_we,
	input  logic [ppsd_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [ppsd_pkg::CFG_DATA_W-1:0]        cfg_data
);

	// signed window sum must hold WINDOW clamped samples of either sign
	localparam int SUM_W  = $clog2(WINDOW*ppsd_pkg::PITCH_LIMIT+1) + 1;
	localparam int MID_W  = SUM_W + ppsd_pkg::TIME_W;
	localparam int RES_W  = $bits(ppsd_pkg::result_t);
	localparam int OCNT_W = $clog2(OUT_DEPTH+1);

	ppsd_pkg::cfg_t cfg_q;

	// front -> mid queue
	logic                          mid_push, mid_full;
	logic signed [SUM_W-1:0]       f_sum;
	logic [ppsd_pkg::TIME_W-1:0]   f_time;
	// mid queue -> back
	logic                          mid_pop, mid_empty;
	logic [MID_W-1:0]              mid_rd;
	// back -> result queue
	logic                          out_push;
	ppsd_pkg::result_t             out_word, res_head;
	logic [OCNT_W-1:0]             out_count;

	// config write: taken at once, no back-pressure
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_interval <= ppsd_pkg::INTERVAL_RESET;
			cfg_q.deadband     <= ppsd_pkg::DEADBAND_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				ppsd_pkg::REG_MIN_INTERVAL: begin
					cfg_q.min_interval <= cfg_data[ppsd_pkg::INTERVAL_W-1:0];
				end
				ppsd_pkg::REG_DEADBAND: begin
					cfg_q.deadband <= cfg_data[ppsd_pkg::DEADBAND_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	ppsd_front #(
		.WINDOW (WINDOW),
		.SUM_W  (SUM_W)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.pitch_sample (pitch_sample),
		.time_ms      (time_ms),
		.mid_full     (mid_full),
		.mid_push     (mid_push),
		.mid_sum      (f_sum),
		.mid_time     (f_time)
	);

	// decoupling queue: new window sum and timestamp per word
	ppsd_fifo #(
		.WIDTH (MID_W),
		.DEPTH (MID_DEPTH)
	) u_mid_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mid_push),
		.wr_data ({f_sum, f_time}),
		.full    (mid_full),
		.rd_en   (mid_pop),
		.rd_data (mid_rd),
		.empty   (mid_empty),
		.count   ()
	);

	ppsd_back #(
		.WINDOW    (WINDOW),
		.SUM_W     (SUM_W),
		.OUT_DEPTH (OUT_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.mid_empty (mid_empty),
		.mid_sum   ($signed(mid_rd[MID_W-1 -: SUM_W])),
		.mid_time  (mid_rd[ppsd_pkg::TIME_W-1:0]),
		.mid_pop   (mid_pop),
		.out_count (out_count),
		.out_push  (out_push),
		.out_word  (out_word)
	);

	// result queue; head word drives the result ports
	ppsd_fifo #(
		.WIDTH (RES_W),
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (out_push),
		.wr_data (out_word),
		.full    (),
		.rd_en   (pop),
		.rd_data (res_head),
		.empty   (empty),
		.count   (out_count)
	);

	assign step_detected = res_head.step_detected;
	assign total_steps   = res_head.total_steps;
	assign trend         = res_head.trend;

endmodule

FILE: sv/ppsd_fifo.sv
// Small register FIFO used between the front and back parts and on the result side.
module ppsd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = ppsd_pkg::MID_DEPTH_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [WIDTH-1:0]             wr_data,
	output logic                         full,
	input  logic                         rd_en,
	output logic [WIDTH-1:0]             rd_data,
	output logic                         empty,
	output logic [$clog2(DEPTH+1)-1:0]   count
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH+1);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr, do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign rd_data = store_q[rd_ptr_q];
	assign do_wr   = wr_en & ~full;
	assign do_rd   = rd_en & ~empty;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(DEPTH-1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (do_wr) begin
			store_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_rd) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: sv/ppsd_front.sv
// Front part: clamps the sample, shifts the window and keeps the running sum.
module ppsd_front #(
	parameter int WINDOW = ppsd_pkg::WINDOW_DEFAULT,
	parameter int SUM_W  = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic signed [ppsd_pkg::PITCH_W-1:0] pitch_sample,
	input  logic [ppsd_pkg::TIME_W-1:0]         time_ms,
	input  logic                                mid_full,
	output logic                                mid_push,
	output logic signed [SUM_W-1:0]             mid_sum,
	output logic [ppsd_pkg::TIME_W-1:0]         mid_time
);

	localparam int PW = ppsd_pkg::PITCH_W;
	localparam logic signed [PW-1:0] LIM_POS = PW'(ppsd_pkg::PITCH_LIMIT);
	localparam logic signed [PW-1:0] LIM_NEG = -LIM_POS;

	logic signed [PW-1:0]    window_q [WINDOW];
	logic signed [SUM_W-1:0] sum_q, sum_next;
	logic signed [PW-1:0]    pitch_sat;
	logic                    accept;

	assign accept = push & ~mid_full;
	assign full   = mid_full;

	always_comb begin
		if (pitch_sample > LIM_POS) begin
			pitch_sat = LIM_POS;
		end else if (pitch_sample < LIM_NEG) begin
			pitch_sat = LIM_NEG;
		end else begin
			pitch_sat = pitch_sample;
		end
		// oldest sample drops out at the tail of the shift line
		sum_next = sum_q - SUM_W'(window_q[WINDOW-1]) + SUM_W'(pitch_sat);
	end

	assign mid_push = accept;
	assign mid_sum  = sum_next;
	assign mid_time = time_ms;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			for (int i = 0; i < WINDOW; i++) begin
				window_q[i] <= '0;
			end
		end else if (accept) begin
			sum_q       <= sum_next;
			window_q[0] <= pitch_sat;
			for (int i = 1; i < WINDOW; i++) begin
				window_q[i] <= window_q[i-1];
			end
		end
	end

endmodule

FILE: sv/ppsd_back.sv
// Back part: average by reciprocal multiply, trend tracking and step counting.
module ppsd_back #(
	parameter int WINDOW    = ppsd_pkg::WINDOW_DEFAULT,
	parameter int SUM_W     = 24,
	parameter int OUT_DEPTH = ppsd_pkg::OUT_DEPTH_DEFAULT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ppsd_pkg::cfg_t                     cfg,
	input  logic                               mid_empty,
	input  logic signed [SUM_W-1:0]            mid_sum,
	input  logic [ppsd_pkg::TIME_W-1:0]        mid_time,
	output logic                               mid_pop,
	input  logic [$clog2(OUT_DEPTH+1)-1:0]     out_count,
	output logic                               out_push,
	output ppsd_pkg::result_t                  out_word
);

	localparam int PW      = ppsd_pkg::PITCH_W;
	localparam int TW      = ppsd_pkg::TIME_W;
	localparam int CW      = ppsd_pkg::COUNT_W;
	localparam int CNT_W   = $clog2(OUT_DEPTH+1);
	localparam int SUM_MAX = WINDOW * ppsd_pkg::PITCH_LIMIT;
	localparam int U_W     = $clog2(2*SUM_MAX+1);
	localparam int SH      = $clog2(2*SUM_MAX*WINDOW+1);
	localparam int RECIP   = ((2**SH) + WINDOW - 1) / WINDOW;
	localparam int M_W     = SH + 1;
	localparam int P_W     = U_W + M_W;
	localparam int Q_W     = $clog2(2*ppsd_pkg::PITCH_LIMIT+1);
	localparam int CMP_W   = PW + 2;

	// s1: average and timestamp
	logic                       v_s1;
	logic signed [PW-1:0]       avg_s1;
	logic [TW-1:0]              time_s1;

	// carried state
	logic signed [PW-1:0]              prev_avg_q;
	logic [ppsd_pkg::TREND_W-1:0]      trend_q;
	logic [TW-1:0]                     last_step_q;
	logic [CW-1:0]                     count_q;

	logic                       issue;
	logic signed [SUM_W:0]      u_wide;
	logic [U_W-1:0]             u;
	logic [P_W-1:0]             prod;
	logic [Q_W-1:0]             q;
	logic signed [Q_W:0]        avg_wide;

	logic signed [CMP_W-1:0]           avg_x, prev_x, db_x;
	logic                              rise, fall, elapsed_ok, step;
	logic [ppsd_pkg::TREND_W-1:0]      trend_new;
	logic [CW-1:0]                     count_new;

	// room in the result FIFO for the word in s1 plus the new one
	assign issue   = ~mid_empty && (({1'b0, out_count} + (CNT_W+1)'(v_s1)) <
		(CNT_W+1)'(OUT_DEPTH));
	assign mid_pop = issue;

	// floor(sum / WINDOW) = floor((sum + offset) / WINDOW) - PITCH_LIMIT
	always_comb begin
		u_wide   = (SUM_W+1)'(mid_sum) + (SUM_W+1)'(SUM_MAX);
		u        = u_wide[U_W-1:0];
		prod     = P_W'(u) * P_W'(RECIP);
		q        = prod[SH +: Q_W];
		avg_wide = $signed({1'b0, q}) - $signed((Q_W+1)'(ppsd_pkg::PITCH_LIMIT));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			avg_s1  <= avg_wide[PW-1:0];
			time_s1 <= mid_time;
		end
	end

	always_comb begin
		avg_x      = CMP_W'(avg_s1);
		prev_x     = CMP_W'(prev_avg_q);
		db_x       = $signed({{(CMP_W-ppsd_pkg::DEADBAND_W){1'b0}}, cfg.deadband});
		rise       = avg_x > (prev_x + db_x);
		fall       = avg_x < (prev_x - db_x);
		if (rise) begin
			trend_new = ppsd_pkg::TREND_RISING;
		end else if (fall) begin
			trend_new = ppsd_pkg::TREND_FALLING;
		end else begin
			trend_new = trend_q;
		end
		// a timestamp behind the last step never passes
		elapsed_ok = {1'b0, time_s1} >
			({1'b0, last_step_q} + (TW+1)'(cfg.min_interval));
		step       = (trend_new != trend_q) && elapsed_ok;
		if (step && (count_q != '1)) begin
			count_new = count_q + 1'b1;
		end else begin
			count_new = count_q;
		end
	end

	assign out_push               = v_s1;
	assign out_word.step_detected = step;
	assign out_word.total_steps   = count_new;
	assign out_word.trend         = trend_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_avg_q  <= '0;
			trend_q     <= ppsd_pkg::TREND_UNKNOWN;
			last_step_q <= '0;
			count_q     <= '0;
		end else if (v_s1) begin
			prev_avg_q <= avg_s1;
			trend_q    <= trend_new;
			count_q    <= count_new;
			if (step) begin
				last_step_q <= time_s1;
			end
		end
	end

endmodule

FILE: tb/sv/tb_top.sv
// Testbench for pitch_peak_step_detector_unit: sample stimulus, step prediction and word checks.
`timescale 1ns / 1ps

module tb_top;
	import ppsd_pkg::*;

	// Window length and settle time after the last word.
	localparam int AVG_LEN      = WINDOW_DEFAULT;
	localparam int SETTLE       = 8;
	localparam int RANDOM_ITEMS = 200;
	localparam int RAW_MAX      = 2 ** (PITCH_W - 1) - 1;
	localparam int RAW_MIN      = -(2 ** (PITCH_W - 1));

	// Receiver stall patterns
	typedef enum logic [1:0] {
		DRAIN_ALL,
		DRAIN_HALF,
		DRAIN_SPARSE,
		DRAIN_MOST
	} pop_style_e;

	logic                        clk;
	logic                        arst_n;
	logic                        push;
	logic                        full;
	logic signed [PITCH_W-1:0]   pitch_sample;
	logic [TIME_W-1:0]           time_ms;
	logic                        empty;
	logic                        pop;
	logic                        step_detected;
	logic [COUNT_W-1:0]          total_steps;
	logic [TREND_W-1:0]          trend;
	logic                        cfg_we;
	logic [CFG_INDEX_W-1:0]      cfg_index;
	logic [CFG_DATA_W-1:0]       cfg_data;

	// Predicted detector state, kept alongside the DUT
	logic signed [PITCH_W-1:0]   win_q [AVG_LEN];
	int                          win_sum;
	int                          win_slot;
	int                          prev_avg;
	logic [TREND_W-1:0]          trend_now;
	logic [TIME_W-1:0]           last_step_ms;
	logic [COUNT_W-1:0]          step_total;
	logic [INTERVAL_W-1:0]       gap_ms_reg;
	logic [DEADBAND_W-1:0]       deadband_reg;

	// Step words still owed by the DUT, oldest first
	result_t                     step_words_due [$];
	int                          bad_words;

	// Sender and receiver pacing
	logic [TIME_W-1:0]           clock_ms;
	int                          samples_fed;
	int                          burst_left;
	bit                          steady_send;
	int                          hold_request;
	int                          hold_left;
	int                          style_left;
	pop_style_e                  pop_style;

	pitch_peak_step_detector_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.pitch_sample  (pitch_sample),
		.time_ms       (time_ms),
		.empty         (empty),
		.pop           (pop),
		.step_detected (step_detected),
		.total_steps   (total_steps),
		.trend         (trend),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Advance the predicted detector by one accepted sample and queue the word it owes.
	function automatic void predict_sample(input logic signed [PITCH_W-1:0] raw,
			input logic [TIME_W-1:0] now);
		int                  p;
		int                  avg;
		int                  db;
		longint              elapsed;
		longint              then_ms;
		longint              min_gap;
		logic [TREND_W-1:0]  old_trend;
		logic                stepped;
		result_t             w;
		p = raw;
		// out-of-range pitch is clipped before it enters the window
		if (p > PITCH_LIMIT)
			p = PITCH_LIMIT;
		if (p < -PITCH_LIMIT)
			p = -PITCH_LIMIT;
		win_sum = win_sum - int'(win_q[win_slot]) + p;
		win_q[win_slot] = p[PITCH_W-1:0];
		win_slot = (win_slot == AVG_LEN - 1) ? 0 : win_slot + 1;
		// average rounds toward minus infinity
		if (win_sum >= 0)
			avg = win_sum / AVG_LEN;
		else
			avg = -((-win_sum + AVG_LEN - 1) / AVG_LEN);
		db = deadband_reg;
		old_trend = trend_now;
		// a move inside the deadband keeps whatever trend there was, unknown included
		if (avg > prev_avg + db)
			trend_now = TREND_RISING;
		else if (avg < prev_avg - db)
			trend_now = TREND_FALLING;
		// signed elapsed time: a stamp behind the last step never passes
		elapsed = now;
		then_ms = last_step_ms;
		elapsed = elapsed - then_ms;
		min_gap = gap_ms_reg;
		stepped = (old_trend != trend_now) && (elapsed > min_gap);
		if (stepped) begin
			// count sticks at all-ones, the step flag and stamp still move
			if (step_total != '1)
				step_total++;
			last_step_ms = now;
		end
		prev_avg = avg;
		w.step_detected = stepped;
		w.total_steps   = step_total;
		w.trend         = trend_now;
		step_words_due.push_back(w);
	endfunction

	function automatic void note_bad_word(input string what, input result_t want,
			input result_t got);
		bad_words++;
		if (bad_words <= 10)
			$display("%0t %s: expected step=%0d total=%0d trend=%0d, got step=%0d total=%0d trend=%0d",
				$time, what, want.step_detected, want.total_steps, want.trend,
				got.step_detected, got.total_steps, got.trend);
	endfunction

	// Offer one sample word; burst/gap pacing unless steady_send is set.
	task automatic send_sample(input logic signed [PITCH_W-1:0] pitch,
			input logic [TIME_W-1:0] stamp);
		int gap;
		if (!steady_send && burst_left == 0) begin
			gap = $urandom_range(1, 8);
			@(negedge clk);
			push <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			burst_left = $urandom_range(1, 24);
		end
		if (burst_left > 0)
			burst_left--;
		@(negedge clk);
		push         <= 1'b1;
		pitch_sample <= pitch;
		time_ms      <= stamp;
		do
			@(posedge clk);
		while (full);
		predict_sample(pitch, stamp);
		samples_fed++;
	endtask

	// Stop offering and wait for every owed word, then let the pipe settle.
	task automatic wait_drained();
		@(negedge clk);
		push <= 1'b0;
		while (step_words_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Both registers in one go, cfg_we held across the pair; only called when drained.
	task automatic set_registers(input logic [CFG_DATA_W-1:0] interval_val,
			input logic [CFG_DATA_W-1:0] deadband_val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_MIN_INTERVAL;
		cfg_data  <= interval_val;
		@(negedge clk);
		cfg_index <= REG_DEADBAND;
		cfg_data  <= deadband_val;
		@(negedge clk);
		cfg_we <= 1'b0;
		gap_ms_reg   = interval_val[INTERVAL_W-1:0];
		deadband_reg = deadband_val[DEADBAND_W-1:0];
	endtask

	// Walking-like pitch: triangle swing with jitter, timestamps moving forward.
	task automatic stride_segment(input int count, input int amp, input int period,
			input int dt_lo, input int dt_hi);
		int v;
		int phase;
		int half;
		int jit;
		half = period / 2;
		jit  = amp / 16 + 1;
		for (int i = 0; i < count; i++) begin
			phase = i % period;
			if (phase < half)
				v = -amp + (2 * amp * phase) / half;
			else
				v = amp - (2 * amp * (phase - half)) / (period - half);
			v = v + int'($urandom_range(0, 2 * jit)) - jit;
			if (v > RAW_MAX)
				v = RAW_MAX;
			if (v < RAW_MIN)
				v = RAW_MIN;
			clock_ms = clock_ms + $urandom_range(dt_lo, dt_hi);
			send_sample(v[PITCH_W-1:0], clock_ms);
		end
	endtask

	// Field extremes, clipping, floor rounding, deadband hold, time running backwards.
	task automatic test_directed_extremes();
		send_sample(17'sd0, 40'd0);                 // unknown trend held
		send_sample(-17'sd1, 40'd10);               // floor of a small negative sum
		send_sample(17'sh0FFFF, 40'd100);           // top raw code, clipped
		send_sample(17'sh10000, 40'd400);           // bottom raw code, clipped
		send_sample(17'sd46081, 40'd700);           // just over the limit
		send_sample(-17'sd46081, 40'd1000);
		send_sample(17'sd46080, 40'd1300);          // exactly on the limits
		send_sample(-17'sd46080, 40'd1600);
		send_sample(17'sd46080, 40'd1900);          // interval boundary
		send_sample(-17'sd46080, 40'd2201);
		send_sample(17'sd46080, 40'd200);           // stamp behind the last step
		send_sample(-17'sd46080, 40'd250);
		send_sample(17'sd46080, 40'hFF_FFFF_FFFF);  // all-ones stamp
		send_sample(-17'sd46080, 40'd0);            // and straight back to zero
		send_sample(17'sd5, 40'd400);               // small moves inside the deadband
		send_sample(17'sd5, 40'd800);
		send_sample(17'sd5, 40'd1200);
		send_sample(17'sd0, 40'd1600);
		clock_ms = 40'd2000;
		wait_drained();
	endtask

	// Register extremes and a couple of ordinary values, a stride run under each.
	task automatic test_register_settings();
		logic [CFG_DATA_W-1:0] iv [4];
		logic [CFG_DATA_W-1:0] dv [4];
		iv = '{16'd0, 16'hFFFF, 16'd1, INTERVAL_RESET};
		dv = '{16'd0, 16'hFFFF, 16'd1, 16'(DEADBAND_RESET)};
		for (int k = 0; k < 4; k++) begin
			set_registers(iv[k], dv[k]);
			stride_segment(30, 20000, $urandom_range(6, 14), 0, int'(iv[k]) / 4 + 80);
			wait_drained();
		end
	endtask

	// Reader holds off while the sender keeps pushing: both queues fill, full rises.
	task automatic test_backpressure();
		steady_send  = 1'b1;
		hold_request = 150;
		stride_segment(40, 15000, 10, 20, 120);
		steady_send  = 1'b0;
		wait_drained();
	endtask

	// Mostly stride sequences with random shape, some raw noise and timestamp jumps.
	task automatic test_random_walk();
		int start;
		int cfg_at;
		int pick;
		int amp;
		int n;
		start  = samples_fed;
		cfg_at = samples_fed;
		set_registers(16'($urandom_range(0, 600)), 16'($urandom_range(0, 300)));
		while (samples_fed - start < RANDOM_ITEMS) begin
			if (samples_fed - cfg_at >= 100) begin
				// pause until everything owed is back, then new settings
				wait_drained();
				if ($urandom_range(0, 3) == 0)
					set_registers(16'($urandom), 16'($urandom));
				else
					set_registers(16'($urandom_range(0, 600)), 16'($urandom_range(0, 300)));
				cfg_at = samples_fed;
			end
			steady_send = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 19);
			if (pick >= 15 && pick <= 17) begin
				// raw noise, every code of the 17-bit field possible
				n = $urandom_range(5, 20);
				for (int i = 0; i < n; i++) begin
					clock_ms = clock_ms + $urandom_range(0, 200);
					send_sample(17'($urandom_range(0, 32'h1FFFF)), clock_ms);
				end
			end else begin
				if (pick >= 18) begin
					// stamp jumps: anywhere in the 40-bit range, or backwards
					if ($urandom_range(0, 1) == 1)
						clock_ms = {8'($urandom_range(0, 255)), 32'($urandom)};
					else
						clock_ms = clock_ms - $urandom_range(1, 5000);
				end
				if ($urandom_range(0, 7) == 0)
					amp = $urandom_range(40000, 65000);
				else
					amp = $urandom_range(300, 30000);
				stride_segment($urandom_range(10, 40), amp, $urandom_range(4, 30), 20, 150);
			end
		end
		steady_send = 1'b0;
		wait_drained();
	endtask

	// Receiver: a long hold when asked, otherwise a stall pattern that changes now and then.
	always @(negedge clk) begin
		if (hold_request > 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else begin
			if (style_left == 0) begin
				pop_style  = pop_style_e'($urandom_range(0, 3));
				style_left = $urandom_range(20, 100);
			end
			style_left--;
			case (pop_style)
				DRAIN_ALL:    pop <= 1'b1;
				DRAIN_HALF:   pop <= ($urandom_range(0, 1) == 1);
				DRAIN_SPARSE: pop <= ($urandom_range(0, 4) == 0);
				default:      pop <= ($urandom_range(0, 4) != 0);
			endcase
		end
	end

	// Every popped word against the oldest one owed, field by field.
	always @(posedge clk) begin : check_words
		result_t got;
		result_t want;
		if (arst_n && pop && !empty) begin
			got.step_detected = step_detected;
			got.total_steps   = total_steps;
			got.trend         = trend;
			if (step_words_due.size() == 0) begin
				note_bad_word("word with nothing owed", '0, got);
			end else begin
				want = step_words_due.pop_front();
				if (got.step_detected !== want.step_detected ||
						got.total_steps !== want.total_steps ||
						got.trend !== want.trend)
					note_bad_word("word mismatch", want, got);
			end
		end
	end

	initial begin
		arst_n       = 1'b0;
		push         = 1'b0;
		pop          = 1'b0;
		pitch_sample = '0;
		time_ms      = '0;
		cfg_we       = 1'b0;
		cfg_index    = REG_MIN_INTERVAL;
		cfg_data     = '0;
		// predictor starts from the reset state
		for (int i = 0; i < AVG_LEN; i++)
			win_q[i] = '0;
		win_sum      = 0;
		win_slot     = 0;
		prev_avg     = 0;
		trend_now    = TREND_UNKNOWN;
		last_step_ms = '0;
		step_total   = '0;
		gap_ms_reg   = INTERVAL_RESET;
		deadband_reg = DEADBAND_RESET;
		bad_words    = 0;
		clock_ms     = '0;
		samples_fed  = 0;
		burst_left   = 0;
		steady_send  = 1'b0;
		hold_request = 0;
		hold_left    = 0;
		style_left   = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_extremes();
		test_register_settings();
		test_backpressure();
		test_random_walk();

		if (step_words_due.size() != 0)
			$display("%0d words never arrived", step_words_due.size());
		if (bad_words == 0 && step_words_due.size() == 0) begin
			$display("PASS pitch_peak_step_detector_unit");
		end else begin
			$display("FAIL pitch_peak_step_detector_unit");
		end
		$finish;
	end

	// Hard stop, far beyond the slowest correct run.
	initial begin
		#3_000_000;
		$display("FAIL pitch_peak_step_detector_unit");
		$finish;
	end

endmodule

FILE: pitch_peak_step_detector_unit.f
sv/ppsd_pkg.sv
sv/ppsd_fifo.sv
sv/ppsd_front.sv
sv/ppsd_back.sv
sv/pitch_peak_step_detector_unit.sv
tb/sv/tb_top.sv
